>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the terminal engine modules. Each macro
// expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ATE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ate: assertion failed");
// next-cycle implication
`define ATE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ate: assertion failed");
`else
`define ATE_ASSERT_NOW(lbl, ante, cons)
`define ATE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/ate_pkg.sv
// ----------------------------------------------------------------------------
// ate_pkg
// Shared types, character codes and constants of the text terminal engine.
// ----------------------------------------------------------------------------
package ate_pkg;

  // Screen command codes
  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_SCROLL = 2'd2;

  // Register indexes (address bit 2)
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // Reset values
  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET = 8'd25;
  localparam logic [3:0] FORE_RESET = 4'd10;
  localparam logic [3:0] BACK_RESET = 4'd0;

  // Control characters
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] CH_H     = 8'h48;  // 'H'
  localparam logic [7:0] CH_J     = 8'h4A;  // 'J'
  localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
  localparam logic [7:0] CH_D0    = 8'h30;  // '0'
  localparam logic [7:0] CH_D1    = 8'h31;
  localparam logic [7:0] CH_D2    = 8'h32;
  localparam logic [7:0] CH_D3    = 8'h33;
  localparam logic [7:0] CH_D4    = 8'h34;
  localparam logic [7:0] CH_D7    = 8'h37;
  localparam logic [7:0] CH_D9    = 8'h39;

  localparam logic [7:0] ROW_MAX = 8'd254;

  // ANSI colour digit to VGA palette index
  localparam logic [2:0] VGA_OF_DIGIT [8] = '{3'd0, 3'd4, 3'd2, 3'd6,
                                              3'd1, 3'd5, 3'd3, 3'd7};

  // One screen command
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] glyph;
    logic [7:0] row;
    logic [7:0] column;
    logic [3:0] fore_color;
    logic [3:0] back_color;
    logic       last_result;
  } ate_res_t;

  // Up to two commands produced by one byte
  typedef struct packed {
    logic     vld0;
    logic     vld1;
    ate_res_t res0;
    ate_res_t res1;
  } ate_push_t;

  // Screen geometry from the register block
  typedef struct packed {
    logic [7:0] cols;
    logic [7:0] rows;
  } ate_cfg_t;

endpackage

>>> design/ate_chan_if.sv
// ----------------------------------------------------------------------------
// ate_chan_if
// Valid/ready channels: text bytes in, screen commands out.
// ----------------------------------------------------------------------------
interface ate_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_write;

  modport source (output valid, output text_byte, output end_of_write, input ready);
  modport sink   (input valid, input text_byte, input end_of_write, output ready);
endinterface

interface ate_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] glyph;
  logic [7:0] row;
  logic [7:0] column;
  logic [3:0] fore_color;
  logic [3:0] back_color;
  logic       last_result;

  modport source (output valid, output command, output glyph, output row, output column,
                  output fore_color, output back_color, output last_result, input ready);
  modport sink   (input valid, input command, input glyph, input row, input column,
                  input fore_color, input back_color, input last_result, output ready);
endinterface

>>> design/ate_cfg.sv
// ----------------------------------------------------------------------------
// ate_cfg
// APB register block holding the screen width and height.
// ----------------------------------------------------------------------------
module ate_cfg
  import ate_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output ate_cfg_t    cfg
);

  logic [7:0] cols_r;
  logic [7:0] rows_r;
  logic       wr_en;

  // write strobe; low address bits are byte lanes and ignored
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_COLS) begin
        cols_r <= pwdata[7:0];
      end else begin
        rows_r <= pwdata[7:0];
      end
    end
  end

  // read back
  assign prdata = (paddr[2] == REG_COLS) ? {24'd0, cols_r} : {24'd0, rows_r};

  assign cfg.cols = cols_r;
  assign cfg.rows = rows_r;

endmodule

>>> design/ate_core.sv
// ----------------------------------------------------------------------------
// ate_core
// Input register, escape parser, cursor and colour state. Turns one byte
// into up to two screen commands per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ate_core
  import ate_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ate_in_if.sink    in_chan,
  input  ate_cfg_t  cfg,
  input  logic      q_room,
  output ate_push_t push
);

  typedef enum logic [2:0] {
    PH_TEXT     = 3'd0,
    PH_ESC      = 3'd1,
    PH_CSI      = 3'd2,
    PH_CSI2     = 3'd3,
    PH_SGR      = 3'd4,
    PH_SGR_FG   = 3'd5,
    PH_SGR_BG   = 3'd6,
    PH_SGR_SKIP = 3'd7
  } phase_t;

  // input stage
  logic       stg_vld_r;
  logic [7:0] stg_byte_r;
  logic       stg_eow_r;
  logic       advance;
  logic       in_take;

  // terminal state
  phase_t     phase_r, phase_nxt;
  logic [7:0] row_r, row_nxt;
  logic [7:0] col_r, col_nxt;
  logic [3:0] fore_r, fore_nxt;
  logic [3:0] back_r, back_nxt;
  logic       wrap_r, wrap_nxt;
  logic       bright_r, bright_nxt;

  // decode scratch
  logic       do_print, do_clear, do_sgr, do_nl;
  logic       put_vld, scroll_vld;
  logic [7:0] pb, put_glyph;
  phase_t     sph;
  logic       sbr;
  logic [7:0] eff_c, eff_r;
  logic [8:0] c_inc, r_inc, nl_r9;
  logic       nl_scroll;
  logic [7:0] nl_row;
  logic [3:0] sgr_col;
  ate_res_t   put_res, clr_res, scr_res;

  assign advance        = stg_vld_r & q_room;
  assign in_chan.ready  = ~stg_vld_r | q_room;
  assign in_take        = in_chan.valid & in_chan.ready;

  // effective geometry: zero counts as one
  assign eff_c = (cfg.cols == 8'd0) ? 8'd1 : cfg.cols;
  assign eff_r = (cfg.rows == 8'd0) ? 8'd1 : cfg.rows;

  // line feed target
  assign r_inc     = {1'b0, row_r} + 9'd1;
  assign nl_scroll = (r_inc >= {1'b0, eff_r});
  assign nl_r9     = nl_scroll ? (r_inc - 9'd1) : r_inc;
  assign nl_row    = (nl_r9 > {1'b0, ROW_MAX}) ? ROW_MAX : nl_r9[7:0];
  assign c_inc     = {1'b0, col_r} + 9'd1;

  // byte decode and state update
  always_comb begin
    pb         = stg_byte_r;
    phase_nxt  = phase_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    fore_nxt   = fore_r;
    back_nxt   = back_r;
    wrap_nxt   = wrap_r;
    bright_nxt = bright_r;
    do_print   = 1'b0;
    do_clear   = 1'b0;
    do_sgr     = 1'b0;
    do_nl      = 1'b0;
    put_vld    = 1'b0;
    put_glyph  = pb;
    sph        = phase_r;
    sbr        = bright_r;
    sgr_col    = 4'd0;

    // parser phase
    case (phase_r)
      PH_TEXT: begin
        if (pb == CH_ESC) begin
          phase_nxt = PH_ESC;
        end else begin
          do_print = 1'b1;
        end
      end
      PH_ESC: begin
        phase_nxt = (pb == CH_LBRK) ? PH_CSI : PH_TEXT;
        do_print  = (pb != CH_LBRK);
      end
      PH_CSI: begin
        if (pb == CH_H) begin
          row_nxt   = 8'd0;
          col_nxt   = 8'd0;
          phase_nxt = PH_TEXT;
        end else if (pb == CH_D2) begin
          phase_nxt = PH_CSI2;
        end else if (pb == CH_D3 || pb == CH_D4 || pb == CH_D9 ||
                     pb == CH_D1 || pb == CH_D0) begin
          do_sgr = 1'b1;
          sph    = PH_SGR;
          sbr    = 1'b0;
        end else begin
          phase_nxt = PH_TEXT;
          do_print  = 1'b1;
        end
      end
      PH_CSI2: begin
        phase_nxt = PH_TEXT;
        do_clear  = (pb == CH_J);
        do_print  = (pb != CH_J);
      end
      default: begin
        do_sgr = 1'b1;
      end
    endcase

    // SGR colour parsing
    if (do_sgr) begin
      phase_nxt  = sph;
      bright_nxt = sbr;
      if (sph == PH_SGR_SKIP) begin
        phase_nxt = PH_SGR_BG;
      end else if (pb == CH_M) begin
        phase_nxt  = PH_TEXT;
        bright_nxt = 1'b0;
      end else if (sph == PH_SGR) begin
        case (pb)
          CH_D3: begin phase_nxt = PH_SGR_FG;   bright_nxt = 1'b0; end
          CH_D4: begin phase_nxt = PH_SGR_BG;   bright_nxt = 1'b0; end
          CH_D9: begin phase_nxt = PH_SGR_FG;   bright_nxt = 1'b1; end
          CH_D1: begin phase_nxt = PH_SGR_SKIP; bright_nxt = 1'b1; end
          CH_D0: begin
            fore_nxt   = FORE_RESET;
            back_nxt   = BACK_RESET;
            bright_nxt = 1'b0;
          end
          default: begin end
        endcase
      end else if (pb >= CH_D0 && pb <= CH_D7) begin
        sgr_col = {sbr, VGA_OF_DIGIT[pb[2:0]]};
        if (sph == PH_SGR_FG) begin
          fore_nxt = sgr_col;
        end else begin
          back_nxt = sgr_col;
        end
        phase_nxt  = PH_SGR;
        bright_nxt = 1'b0;
      end
    end

    // printable and control characters
    if (do_print) begin
      case (pb)
        CH_BS: begin
          if (col_r != 8'd0) begin
            col_nxt = col_r - 8'd1;
          end else begin
            col_nxt = eff_c - 8'd1;
            if (row_r != 8'd0) begin
              row_nxt = row_r - 8'd1;
            end
          end
        end
        CH_LF: begin
          if (wrap_r) begin
            wrap_nxt = 1'b0;
          end else begin
            do_nl = 1'b1;
          end
        end
        CH_CR: begin
          col_nxt = 8'd0;
        end
        CH_DEL: begin
          put_vld   = 1'b1;
          put_glyph = CH_SPACE;
        end
        default: begin
          put_vld = 1'b1;
          if (c_inc >= {1'b0, eff_c}) begin
            do_nl    = 1'b1;
            wrap_nxt = 1'b1;
          end else begin
            col_nxt = c_inc[7:0];
          end
        end
      endcase
    end

    if (do_nl) begin
      col_nxt = 8'd0;
      row_nxt = nl_row;
    end

    // end of write drops an unfinished sequence
    if (stg_eow_r) begin
      phase_nxt  = PH_TEXT;
      bright_nxt = 1'b0;
    end
  end

  assign scroll_vld = do_nl & nl_scroll;

  // command assembly
  always_comb begin
    put_res             = '0;
    put_res.command     = CMD_PUT;
    put_res.glyph       = put_glyph;
    put_res.row         = row_r;
    put_res.column      = col_r;
    put_res.fore_color  = fore_r;
    put_res.back_color  = back_r;
    put_res.last_result = ~scroll_vld;

    clr_res             = '0;
    clr_res.command     = CMD_CLEAR;
    clr_res.back_color  = back_r;
    clr_res.last_result = 1'b1;

    scr_res             = '0;
    scr_res.command     = CMD_SCROLL;
    scr_res.back_color  = back_r;
    scr_res.last_result = 1'b1;

    push.vld0 = advance & (put_vld | do_clear | scroll_vld);
    push.vld1 = advance & put_vld & scroll_vld;
    push.res0 = put_vld ? put_res : (do_clear ? clr_res : scr_res);
    push.res1 = scr_res;
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_byte_r <= in_chan.text_byte;
      stg_eow_r  <= in_chan.end_of_write;
    end
  end

  // control and terminal state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      phase_r   <= PH_TEXT;
      row_r     <= 8'd0;
      col_r     <= 8'd0;
      fore_r    <= FORE_RESET;
      back_r    <= BACK_RESET;
      wrap_r    <= 1'b0;
      bright_r  <= 1'b0;
    end else begin
      if (in_take) begin
        stg_vld_r <= 1'b1;
      end else if (advance) begin
        stg_vld_r <= 1'b0;
      end
      if (advance) begin
        phase_r  <= phase_nxt;
        row_r    <= row_nxt;
        col_r    <= col_nxt;
        fore_r   <= fore_nxt;
        back_r   <= back_nxt;
        wrap_r   <= wrap_nxt;
        bright_r <= bright_nxt;
      end
    end
  end

  // a stalled byte stays in the stage
  `ATE_ASSERT_NEXT(a_stage_hold, stg_vld_r && !q_room, stg_vld_r)
  // the second command of a byte is always a scroll after a put
  `ATE_ASSERT_NOW(a_second_scroll, push.vld1,
                  push.res1.command == CMD_SCROLL && push.res0.command == CMD_PUT)
  // only the final command carries the last flag
  `ATE_ASSERT_NOW(a_last_flag, push.vld1, !push.res0.last_result && push.res1.last_result)

endmodule

>>> design/ate_outq.sv
// ----------------------------------------------------------------------------
// ate_outq
// Three-entry result queue; the head entry drives the output channel.
// Takes up to two commands per cycle, hands out one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ate_outq
  import ate_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ate_push_t push,
  output logic      q_room,
  ate_out_if.source out_chan
);

  logic [1:0] cnt_r, cnt_nxt, cnt_pop;
  ate_res_t   q_r   [3];
  ate_res_t   q_nxt [3];
  logic       pop;

  assign pop    = out_chan.valid & out_chan.ready;
  assign q_room = (cnt_r <= 2'd1);

  // shift on pop, then append the new commands behind what is left
  always_comb begin
    cnt_pop  = cnt_r - {1'b0, pop};
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = pop ? q_r[2] : q_r[1];
    q_nxt[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if (push.vld0 && cnt_pop == 2'(i)) begin
        q_nxt[i] = push.res0;
      end
      if (push.vld1 && (cnt_pop + 2'd1) == 2'(i)) begin
        q_nxt[i] = push.res1;
      end
    end
    cnt_nxt = cnt_pop + {1'b0, push.vld0} + {1'b0, push.vld1};
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // head entry to the port
  assign out_chan.valid       = (cnt_r != 2'd0);
  assign out_chan.command     = q_r[0].command;
  assign out_chan.glyph       = q_r[0].glyph;
  assign out_chan.row         = q_r[0].row;
  assign out_chan.column      = q_r[0].column;
  assign out_chan.fore_color  = q_r[0].fore_color;
  assign out_chan.back_color  = q_r[0].back_color;
  assign out_chan.last_result = q_r[0].last_result;

  // two-command request comes with its first command
  `ATE_ASSERT_NOW(a_pair_order, push.vld1, push.vld0)
  // writer only pushes when two slots are free
  `ATE_ASSERT_NOW(a_no_overflow, push.vld0, cnt_r <= 2'd1)
  // an empty queue with nothing pushed stays empty
  `ATE_ASSERT_NEXT(a_empty_stays, cnt_r == 2'd0 && !push.vld0, cnt_r == 2'd0)

endmodule

>>> design/ansi_text_terminal_engine_top.sv
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine_top
// Byte-stream text terminal: cursor, colours and escape parsing, producing
// put / clear / scroll screen commands.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle on in_chan while in_chan.ready is high and
// answers with screen commands on out_chan: a put of a glyph at the cursor in
// the current colours, a clear, or a one-line scroll (clear and scroll carry
// only the background colour); the final command of each byte has
// last_result set, and bytes that only move the cursor or feed the escape
// parser give no command. A byte is held in the input register and its
// commands are written into the result queue, whose head entry drives out_chan.
// Sustained rate is one byte per cycle while each byte gives at most one command
// and out_chan is ready; a byte that prints in the last column of the last row
// gives a put and a scroll, handed out one per cycle, and the three-entry result
// queue then holds off input until it has room. Screen width and height live at
// APB addresses 0 and 4 (reset 80 and 25, zero acts as one); the user must write
// them only while the engine is idle, and the block itself does not enforce it.
module ansi_text_terminal_engine_top
  import ate_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ate_in_if.sink      in_chan,
  ate_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ate_cfg_t  cfg;
  ate_push_t push;
  logic      q_room;

  // geometry registers
  ate_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // parser and terminal state
  ate_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg),
    .q_room  (q_room),
    .push    (push)
  );

  // result queue
  ate_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .q_room   (q_room),
    .out_chan (out_chan)
  );

endmodule

>>> sim/ansi_text_terminal_engine_top_tb.sv
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine_top_tb
// Self-checking bench for the text terminal engine. Text bytes are fed over
// the input channel and every screen command that comes out is compared
// field by field with a cycle-free predictor of the cursor, colors, wrap flag
// and escape parser. Screen size is changed over APB between phases, at the
// extremes and at random, with sender gaps and receiver stalls in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ansi_text_terminal_engine_top_tb;
  import ate_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 131;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';' separator, ignored inside SGR

  // Escape parser states of the predictor
  typedef enum logic [2:0] {
    PS_TEXT, PS_ESC, PS_CSI, PS_CSI2, PS_SGR, PS_SGR_FG, PS_SGR_BG, PS_SGR_SKIP
  } parse_state_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eow;
  } text_item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ate_in_if  in_ch ();
  ate_out_if out_ch ();

  ansi_text_terminal_engine_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch.sink),
    .out_chan (out_ch.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bench state
  text_item_t pending_bytes[$];
  ate_res_t   screen_cmd_q[$];
  int         bytes_queued  = 0;
  int         bytes_taken   = 0;
  int         cmds_checked  = 0;
  int         fail_count    = 0;
  int         cycle_count   = 0;
  int         sizes_used    = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_left     = 0;
  logic       hold_req      = 1'b0;
  logic       in_fire       = 1'b0;

  // Predicted engine state
  logic [7:0]   scr_cols   = COLS_RESET;
  logic [7:0]   scr_rows   = ROWS_RESET;
  logic [7:0]   cur_row    = 8'd0;
  logic [7:0]   cur_col    = 8'd0;
  logic [3:0]   pen_fore   = FORE_RESET;
  logic [3:0]   pen_back   = BACK_RESET;
  logic         wrap_armed = 1'b0;
  logic         bright_sel = 1'b0;
  parse_state_t parse_st   = PS_TEXT;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int cols_eff();
    return (scr_cols == 8'd0) ? 1 : int'(scr_cols);
  endfunction

  function automatic int rows_eff();
    return (scr_rows == 8'd0) ? 1 : int'(scr_rows);
  endfunction

  task automatic add_cmd(input logic [1:0] cmd, input logic [7:0] g, input logic [7:0] r,
                         input logic [7:0] c, input logic [3:0] fg, input logic [3:0] bg);
    ate_res_t e;
    e.command     = cmd;
    e.glyph       = g;
    e.row         = r;
    e.column      = c;
    e.fore_color  = fg;
    e.back_color  = bg;
    e.last_result = 1'b0;
    screen_cmd_q.push_back(e);
  endtask

  // Column 0 of the next row; scroll when already at or past the bottom
  task automatic next_line();
    int r;
    r = int'(cur_row) + 1;
    cur_col = 8'd0;
    if (r >= rows_eff()) begin
      add_cmd(CMD_SCROLL, 8'd0, 8'd0, 8'd0, 4'd0, pen_back);
      r--;
    end
    if (r > int'(ROW_MAX)) r = int'(ROW_MAX);
    cur_row = 8'(r);
  endtask

  task automatic print_char(input logic [7:0] b);
    int c;
    case (b)
      CH_BS: begin
        if (cur_col != 8'd0) begin
          cur_col = cur_col - 8'd1;
        end else begin
          cur_col = 8'(cols_eff() - 1);
          if (cur_row != 8'd0) cur_row = cur_row - 8'd1;
        end
      end
      CH_LF: begin
        // a line feed right after a wrap only disarms the flag
        if (wrap_armed) wrap_armed = 1'b0;
        else next_line();
      end
      CH_CR: cur_col = 8'd0;
      CH_DEL: add_cmd(CMD_PUT, CH_SPACE, cur_row, cur_col, pen_fore, pen_back);
      default: begin
        add_cmd(CMD_PUT, b, cur_row, cur_col, pen_fore, pen_back);
        c = int'(cur_col) + 1;
        if (c >= cols_eff()) begin
          next_line();
          wrap_armed = 1'b1;
        end else begin
          cur_col = 8'(c);
        end
      end
    endcase
  endtask

  // One byte inside an SGR color sequence
  task automatic sgr_step(input logic [7:0] b);
    logic [3:0] hue;
    if (parse_st == PS_SGR_SKIP) begin
      parse_st = PS_SGR_BG;
      return;
    end
    if (b == CH_M) begin
      parse_st   = PS_TEXT;
      bright_sel = 1'b0;
      return;
    end
    if (parse_st == PS_SGR) begin
      case (b)
        CH_D3: begin parse_st = PS_SGR_FG;   bright_sel = 1'b0; end
        CH_D4: begin parse_st = PS_SGR_BG;   bright_sel = 1'b0; end
        CH_D9: begin parse_st = PS_SGR_FG;   bright_sel = 1'b1; end
        CH_D1: begin parse_st = PS_SGR_SKIP; bright_sel = 1'b1; end
        CH_D0: begin
          pen_fore   = FORE_RESET;
          pen_back   = BACK_RESET;
          bright_sel = 1'b0;
        end
        default: ;
      endcase
      return;
    end
    if (b >= CH_D0 && b <= CH_D7) begin
      hue = {bright_sel, VGA_OF_DIGIT[b[2:0]]};
      if (parse_st == PS_SGR_FG) pen_fore = hue;
      else pen_back = hue;
      parse_st   = PS_SGR;
      bright_sel = 1'b0;
    end
  endtask

  // Expected commands of one accepted byte
  task automatic predict_byte(input logic [7:0] b, input logic eow);
    int n_before;
    n_before = screen_cmd_q.size();
    case (parse_st)
      PS_TEXT: begin
        if (b == CH_ESC) parse_st = PS_ESC;
        else print_char(b);
      end
      PS_ESC: begin
        if (b == CH_LBRK) begin
          parse_st = PS_CSI;
        end else begin
          parse_st = PS_TEXT;
          print_char(b);
        end
      end
      PS_CSI: begin
        if (b == CH_H) begin
          cur_row  = 8'd0;
          cur_col  = 8'd0;
          parse_st = PS_TEXT;
        end else if (b == CH_D2) begin
          parse_st = PS_CSI2;
        end else if (b == CH_D3 || b == CH_D4 || b == CH_D9 || b == CH_D1 || b == CH_D0) begin
          parse_st   = PS_SGR;
          bright_sel = 1'b0;
          sgr_step(b);
        end else begin
          parse_st = PS_TEXT;
          print_char(b);
        end
      end
      PS_CSI2: begin
        parse_st = PS_TEXT;
        if (b == CH_J) add_cmd(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 4'd0, pen_back);
        else print_char(b);
      end
      default: sgr_step(b);
    endcase
    // end of write drops any unfinished sequence
    if (eow) begin
      parse_st   = PS_TEXT;
      bright_sel = 1'b0;
    end
    if (screen_cmd_q.size() > n_before)
      screen_cmd_q[screen_cmd_q.size() - 1].last_result = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_command(input ate_res_t got);
    ate_res_t want;
    if (screen_cmd_q.size() == 0) begin
      $error("unexpected screen command %0d (glyph %0d)", got.command, got.glyph);
      fail_count++;
      return;
    end
    want = screen_cmd_q.pop_front();
    check_field("command", 8'(want.command), 8'(got.command));
    check_field("glyph", want.glyph, got.glyph);
    check_field("row", want.row, got.row);
    check_field("column", want.column, got.column);
    check_field("fore_color", 8'(want.fore_color), 8'(got.fore_color));
    check_field("back_color", 8'(want.back_color), 8'(got.back_color));
    check_field("last_result", 8'(want.last_result), 8'(got.last_result));
    cmds_checked++;
  endtask

  // Monitor: outputs and accepted requests sampled at the rising edge
  always @(posedge clk) begin : monitor
    ate_res_t got;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.command     = out_ch.command;
      got.glyph       = out_ch.glyph;
      got.row         = out_ch.row;
      got.column      = out_ch.column;
      got.fore_color  = out_ch.fore_color;
      got.back_color  = out_ch.back_color;
      got.last_result = out_ch.last_result;
      check_command(got);
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_byte(in_ch.text_byte, in_ch.end_of_write);
      bytes_taken++;
    end
  end

  // Driver: next pending byte once the current request has gone
  always @(negedge clk) begin : driver
    text_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_bytes.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.text_byte    <= it.b;
        in_ch.end_of_write <= it.eow;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[ansi_text_terminal_engine_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic eow);
    text_item_t it;
    it.b   = b;
    it.eow = eow;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  function automatic logic rand_eow();
    return ($urandom_range(7) == 0);
  endfunction

  // Write a screen register, read it back, update the predictor
  task automatic set_screen_reg(input logic reg_idx, input logic [7:0] val);
    logic [31:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[7:0] !== val) begin
      $error("register %0d readback mismatch: expected %0d, got %0d", reg_idx, val, rd[7:0]);
      fail_count++;
    end
    if (reg_idx == REG_COLS) scr_cols = val;
    else scr_rows = val;
  endtask

  task automatic wait_for_idle();
    while (bytes_taken != bytes_queued || screen_cmd_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 71; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default:       begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
  endtask

  // One random fragment of text: mostly well-formed, some broken or noise
  task automatic queue_random_chunk();
    int kind;
    int n;
    int i;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // printable run
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) push_byte(8'($urandom_range(8'h20, 8'h7E)), rand_eow());
    end else if (kind < 50) begin
      // cursor controls
      case ($urandom_range(3))
        0: push_byte(CH_BS, rand_eow());
        1: push_byte(CH_LF, rand_eow());
        2: push_byte(CH_CR, rand_eow());
        default: push_byte(CH_DEL, rand_eow());
      endcase
    end else if (kind < 72) begin
      // SGR color sequence with one to three codes
      push_byte(CH_ESC, 1'b0);
      push_byte(CH_LBRK, 1'b0);
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(4))
          0: push_byte(CH_D3, 1'b0);
          1: push_byte(CH_D4, 1'b0);
          2: push_byte(CH_D9, 1'b0);
          3: begin
            push_byte(CH_D1, 1'b0);
            push_byte(CH_D0, 1'b0);
          end
          default: ;
        endcase
        // digit 0 alone resets colors; 8 and 9 hit the ignored digits
        push_byte(8'(CH_D0 + $urandom_range(9)), ($urandom_range(31) == 0));
        if (i < n - 1) push_byte(CH_SEMI, 1'b0);
      end
      push_byte(CH_M, rand_eow());
    end else if (kind < 78) begin
      push_byte(CH_ESC, 1'b0);
      push_byte(CH_LBRK, 1'b0);
      push_byte(CH_D2, 1'b0);
      push_byte(CH_J, rand_eow());
    end else if (kind < 84) begin
      push_byte(CH_ESC, 1'b0);
      push_byte(CH_LBRK, 1'b0);
      push_byte(CH_H, rand_eow());
    end else if (kind < 92) begin
      // broken sequences
      push_byte(CH_ESC, 1'b0);
      case ($urandom_range(3))
        0: push_byte(8'($urandom), rand_eow());
        1: begin
          push_byte(CH_LBRK, 1'b0);
          push_byte(8'($urandom), rand_eow());
        end
        2: begin
          push_byte(CH_LBRK, 1'b0);
          push_byte(CH_D2, 1'b0);
          push_byte(8'($urandom), rand_eow());
        end
        default: begin
          push_byte(CH_LBRK, 1'b0);
          push_byte(CH_D3, 1'b1);
        end
      endcase
    end else begin
      push_byte(8'($urandom), 1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    logic [7:0] cols_tab [NUM_PHASES];
    logic [7:0] rows_tab [NUM_PHASES];
    idle_mode_t mode_tab [NUM_PHASES];
    int         ph;
    int         target;

    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = 3'd0;
    pwdata             = 32'd0;
    in_ch.valid        = 1'b0;
    in_ch.text_byte    = 8'd0;
    in_ch.end_of_write = 1'b0;
    out_ch.ready       = 1'b0;

    cols_tab = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd4, 8'd255, 8'd1};
    rows_tab = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd3, 8'd1, 8'd255};
    mode_tab = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                 IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    cols_tab[3] = 8'($urandom_range(2, 12));
    rows_tab[3] = 8'($urandom_range(2, 8));
    cols_tab[4] = 8'($urandom_range(1, 255));
    rows_tab[4] = 8'($urandom_range(1, 255));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size of 80 x 25
    sizes_used++;
    push_byte(8'h41, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    // bright blue on bright blue, with a separator that is ignored
    push_byte(CH_ESC, 1'b0);
    push_byte(CH_LBRK, 1'b0);
    push_byte(CH_D9, 1'b0);
    push_byte(CH_D4, 1'b0);
    push_byte(CH_SEMI, 1'b0);
    push_byte(CH_D1, 1'b0);
    push_byte(CH_D0, 1'b0);
    push_byte(CH_D4, 1'b0);
    push_byte(CH_M, 1'b0);
    // clear, then home
    push_byte(CH_ESC, 1'b0);
    push_byte(CH_LBRK, 1'b0);
    push_byte(CH_D2, 1'b0);
    push_byte(CH_J, 1'b0);
    push_byte(CH_ESC, 1'b0);
    push_byte(CH_LBRK, 1'b0);
    push_byte(CH_H, 1'b0);
    // cursor controls from home: backspace wraps to the last column
    push_byte(CH_BS, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(CH_DEL, 1'b0);
    // escape not followed by a bracket prints the byte
    push_byte(CH_ESC, 1'b0);
    push_byte(8'h58, 1'b0);
    // truncated sequence at end of write
    push_byte(CH_ESC, 1'b0);
    push_byte(CH_LBRK, 1'b0);
    push_byte(CH_D3, 1'b1);

    // Random phases over several screen sizes and idle patterns
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_idle();
      set_screen_reg(REG_COLS, cols_tab[ph]);
      set_screen_reg(REG_ROWS, rows_tab[ph]);
      sizes_used++;
      apply_idle_mode(mode_tab[ph]);
      target = bytes_queued + ITEMS_PER_PHASE;
      while (bytes_queued < target) queue_random_chunk();
      // long receiver hold-off while the sender keeps pushing
      if (mode_tab[ph] == IDLE_NONE) begin
        @(negedge clk);
        hold_req <= 1'b1;
        @(negedge clk);
        hold_req <= 1'b0;
      end
      while (bytes_taken != bytes_queued) @(posedge clk);
    end

    wait_for_idle();
    repeat (20) @(posedge clk);

    $display("Fed %0d text bytes across %0d screen sizes; %0d screen commands checked.",
             bytes_taken, sizes_used, cmds_checked);
    if (fail_count == 0 && screen_cmd_q.size() == 0) begin
      $display("[ansi_text_terminal_engine_top] OK");
    end else begin
      $display("[ansi_text_terminal_engine_top] ERROR");
    end
    $finish;
  end

endmodule
